@@ design/csgc_pkg.sv @@
// Package for the coin store with greedy change: item and result types,
// command and status codes, coin constants and the helpers that decode them.
// No dependencies; every other design file uses it by scoped names.
package csgc_pkg;

  localparam int CENTS_W     = 23;  // width of any amount in cents
  localparam int MB          = 22;  // width of the constant operand of the multiplier
  localparam int QW          = 21;  // width of a greedy quotient, amount / 5 < 2^21
  localparam int RECIP_SHIFT = 24;  // scale of the reciprocal constants
  localparam int NUM_COINS   = 4;

  localparam logic [2:0] CMD_DEPOSIT_ONE = 3'd0;
  localparam logic [2:0] CMD_DEPOSIT_CNT = 3'd1;
  localparam logic [2:0] CMD_TAKE_ONE    = 3'd2;
  localparam logic [2:0] CMD_TAKE_AMOUNT = 3'd3;
  localparam logic [2:0] CMD_EMPTY       = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNKNOWN   = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_TOO_MUCH  = 3'd3;
  localparam logic [2:0] ST_INEXACT   = 3'd4;

  localparam logic [1:0] IDX_FIFTY  = 2'd0;
  localparam logic [1:0] IDX_TWENTY = 2'd1;
  localparam logic [1:0] IDX_TEN    = 2'd2;
  localparam logic [1:0] IDX_FIVE   = 2'd3;
  localparam logic [1:0] IDX_LAST   = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         coin_cents;
    logic [7:0]         add_fifty;
    logic [7:0]         add_twenty;
    logic [7:0]         add_ten;
    logic [7:0]         add_five;
    logic [CENTS_W-1:0] amount_cents;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [CENTS_W-1:0] paid_cents;
    logic [CENTS_W-1:0] total_cents;
  } result_t;

  typedef enum logic [1:0] {
    MUL_VALUE,    // operand times the coin value
    MUL_RECIP,    // operand times the reciprocal of the divisor
    MUL_DIVISOR   // operand times the divisor
  } mul_op_e;

  typedef struct packed {
    mul_op_e    op;
    logic [1:0] idx;
  } mul_req_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } slot_t;

  function automatic logic [5:0] coin_value(input logic [1:0] idx);
    logic [5:0] v;
    case (idx)
      IDX_FIFTY:  v = 6'd50;
      IDX_TWENTY: v = 6'd20;
      IDX_TEN:    v = 6'd10;
      default:    v = 6'd5;
    endcase
    return v;
  endfunction

  // a / 50 is (a >> 1) / 25, a / 20 is (a >> 2) / 5, a / 10 is (a >> 1) / 5.
  function automatic logic [1:0] div_shift(input logic [1:0] idx);
    logic [1:0] s;
    case (idx)
      IDX_FIFTY:  s = 2'd1;
      IDX_TWENTY: s = 2'd2;
      IDX_TEN:    s = 2'd1;
      default:    s = 2'd0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] div_by(input logic [1:0] idx);
    logic [4:0] d;
    case (idx)
      IDX_FIFTY: d = 5'd25;
      default:   d = 5'd5;
    endcase
    return d;
  endfunction

  // floor(2^24 / d): the estimate it gives is the quotient or one below it.
  function automatic logic [MB-1:0] div_recip(input logic [1:0] idx);
    logic [MB-1:0] m;
    case (idx)
      IDX_FIFTY: m = 22'd671088;
      default:   m = 22'd3355443;
    endcase
    return m;
  endfunction

  function automatic slot_t coin_slot(input logic [7:0] cents);
    slot_t s;
    s.hit = 1'b1;
    case (cents)
      8'd50:   s.idx = IDX_FIFTY;
      8'd20:   s.idx = IDX_TWENTY;
      8'd10:   s.idx = IDX_TEN;
      8'd5:    s.idx = IDX_FIVE;
      default: begin
        s.hit = 1'b0;
        s.idx = IDX_FIFTY;
      end
    endcase
    return s;
  endfunction

endpackage

@@ design/csgc_in_if.sv @@
// Input channel of the coin store: valid, ready and one command word.
// Depends on csgc_pkg for the word type.
interface csgc_in_if;
  logic            valid;
  logic            ready;
  csgc_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/csgc_out_if.sv @@
// Output channel of the coin store: valid, ready and one result word.
// Depends on csgc_pkg for the word type.
interface csgc_out_if;
  logic              valid;
  logic              ready;
  csgc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/coin_store_greedy_change_unit.sv @@
// Coin store with greedy change. It keeps saturating counts of 50, 20, 10 and
// 5 cent coins and takes one command word at a time; every command gives one
// result word with a status, the cents paid and the new stored total. A
// word is taken only while the block is idle, and a finished result waits in
// an output register, so the next word may enter before it is collected.
// Every command is paced by the one shared multiplier: the stored total
// takes a product and an accumulate step per coin type, and each greedy step
// of taking an amount runs through reciprocal estimate, back-multiply,
// correction, coin value product and update. The counts are cleared at reset
// and need no clearing pass.
// Depends on csgc_pkg, csgc_in_if, csgc_out_if and csgc_mul_unit.
module coin_store_greedy_change_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  csgc_in_if.sink           in_i,
  csgc_out_if.source        out_o
);

  localparam int CENTS_W = csgc_pkg::CENTS_W;
  localparam int QW      = csgc_pkg::QW;
  localparam int RS      = csgc_pkg::RECIP_SHIFT;
  localparam int AW      = (COUNT_BITS > CENTS_W) ? COUNT_BITS : CENTS_W;
  localparam int PW      = AW + csgc_pkg::MB;
  localparam int TW      = COUNT_BITS + 8;
  localparam int CW      = (TW > CENTS_W) ? TW : CENTS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_TOT_MUL,
    S_TOT_ACC,
    S_EVAL,
    S_DIV_MUL,
    S_DIV_EST,
    S_DIV_FIX,
    S_TAKE_MUL,
    S_TAKE_ACC,
    S_TAKE_END,
    S_WRITE
  } state_e;

  state_e               state_q;
  logic [1:0]           idx_q;
  csgc_pkg::item_t      item_q;
  logic [COUNT_BITS-1:0] count_q [csgc_pkg::NUM_COINS];
  logic [TW-1:0]        acc_q;
  logic [CENTS_W-1:0]   left_q;
  logic [CENTS_W-1:0]   paid_q;
  logic [QW-1:0]        qest_q;
  logic [QW-1:0]        take_q;
  logic [2:0]           status_q;
  logic                 out_valid_q;
  csgc_pkg::result_t    out_data_q;

  csgc_pkg::mul_req_t   mul_req_w;
  logic [AW-1:0]        mul_a_w;
  logic [PW-1:0]        prod_w;
  logic [CENTS_W-1:0]   x_w;
  logic [QW-1:0]        qfix_w;
  logic [CENTS_W-1:0]   rem_w;
  csgc_pkg::slot_t      slot_w;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
                                                    input logic [7:0] more);
    logic [COUNT_BITS:0] s;
    s = {1'b0, c} + (COUNT_BITS+1)'(more);
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  assign x_w    = left_q >> csgc_pkg::div_shift(idx_q);
  assign rem_w  = x_w - prod_w[CENTS_W-1:0];
  assign qfix_w = (rem_w >= CENTS_W'(csgc_pkg::div_by(idx_q))) ? qest_q + QW'(1) : qest_q;
  assign slot_w = csgc_pkg::coin_slot(item_q.coin_cents);

  always_comb begin
    mul_req_w.idx = idx_q;
    case (state_q)
      S_DIV_MUL: begin
        mul_req_w.op = csgc_pkg::MUL_RECIP;
        mul_a_w      = AW'(x_w);
      end
      S_DIV_EST: begin
        mul_req_w.op = csgc_pkg::MUL_DIVISOR;
        mul_a_w      = AW'(prod_w[RS +: QW]);
      end
      S_TAKE_MUL: begin
        mul_req_w.op = csgc_pkg::MUL_VALUE;
        mul_a_w      = AW'(take_q);
      end
      default: begin
        mul_req_w.op = csgc_pkg::MUL_VALUE;
        mul_a_w      = AW'(count_q[idx_q]);
      end
    endcase
  end

  csgc_mul_unit #(
    .A_W (AW)
  ) u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req_w),
    .a_i    (mul_a_w),
    .prod_o (prod_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < csgc_pkg::NUM_COINS; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      // In the write state the output flag is handled below.
      if (out_o.ready && state_q != S_WRITE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            item_q   <= in_i.data;
            status_q <= csgc_pkg::ST_OK;
            paid_q   <= '0;
            acc_q    <= '0;
            idx_q    <= '0;
            if (in_i.data.cmd == csgc_pkg::CMD_TAKE_AMOUNT ||
                in_i.data.cmd == csgc_pkg::CMD_EMPTY) begin
              state_q <= S_TOT_MUL;
            end else begin
              state_q <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          case (item_q.cmd)
            csgc_pkg::CMD_DEPOSIT_ONE: begin
              if (slot_w.hit) begin
                count_q[slot_w.idx] <= sat_add(count_q[slot_w.idx], 8'd1);
              end else begin
                status_q <= csgc_pkg::ST_UNKNOWN;
              end
            end
            csgc_pkg::CMD_DEPOSIT_CNT: begin
              count_q[csgc_pkg::IDX_FIFTY]  <= sat_add(count_q[csgc_pkg::IDX_FIFTY],
                                                       item_q.add_fifty);
              count_q[csgc_pkg::IDX_TWENTY] <= sat_add(count_q[csgc_pkg::IDX_TWENTY],
                                                       item_q.add_twenty);
              count_q[csgc_pkg::IDX_TEN]    <= sat_add(count_q[csgc_pkg::IDX_TEN],
                                                       item_q.add_ten);
              count_q[csgc_pkg::IDX_FIVE]   <= sat_add(count_q[csgc_pkg::IDX_FIVE],
                                                       item_q.add_five);
            end
            csgc_pkg::CMD_TAKE_ONE: begin
              if (!slot_w.hit) begin
                status_q <= csgc_pkg::ST_UNKNOWN;
              end else if (count_q[slot_w.idx] == '0) begin
                status_q <= csgc_pkg::ST_EXHAUSTED;
              end else begin
                count_q[slot_w.idx] <= count_q[slot_w.idx] - COUNT_BITS'(1);
              end
            end
            default: begin
            end
          endcase
          state_q <= S_TOT_MUL;
        end
        S_TOT_MUL: begin
          state_q <= S_TOT_ACC;
        end
        S_TOT_ACC: begin
          acc_q <= acc_q + TW'(prod_w);
          idx_q <= idx_q + 2'd1;
          if (idx_q == csgc_pkg::IDX_LAST) begin
            state_q <= S_EVAL;
          end else begin
            state_q <= S_TOT_MUL;
          end
        end
        S_EVAL: begin
          case (item_q.cmd)
            csgc_pkg::CMD_EMPTY: begin
              paid_q <= CENTS_W'(acc_q);
              acc_q  <= '0;
              for (int i = 0; i < csgc_pkg::NUM_COINS; i++) begin
                count_q[i] <= '0;
              end
              state_q <= S_WRITE;
            end
            csgc_pkg::CMD_TAKE_AMOUNT: begin
              if (CW'(item_q.amount_cents) > CW'(acc_q)) begin
                status_q <= csgc_pkg::ST_TOO_MUCH;
                state_q  <= S_WRITE;
              end else begin
                left_q  <= item_q.amount_cents;
                idx_q   <= '0;
                state_q <= S_DIV_MUL;
              end
            end
            default: begin
              state_q <= S_WRITE;
            end
          endcase
        end
        S_DIV_MUL: begin
          state_q <= S_DIV_EST;
        end
        S_DIV_EST: begin
          qest_q  <= prod_w[RS +: QW];
          state_q <= S_DIV_FIX;
        end
        S_DIV_FIX: begin
          // Never take more coins of this type than the store holds.
          if (AW'(qfix_w) > AW'(count_q[idx_q])) begin
            take_q <= QW'(count_q[idx_q]);
          end else begin
            take_q <= qfix_w;
          end
          state_q <= S_TAKE_MUL;
        end
        S_TAKE_MUL: begin
          count_q[idx_q] <= count_q[idx_q] - COUNT_BITS'(take_q);
          state_q        <= S_TAKE_ACC;
        end
        S_TAKE_ACC: begin
          left_q <= left_q - prod_w[CENTS_W-1:0];
          paid_q <= paid_q + prod_w[CENTS_W-1:0];
          idx_q  <= idx_q + 2'd1;
          if (idx_q == csgc_pkg::IDX_LAST) begin
            state_q <= S_TAKE_END;
          end else begin
            state_q <= S_DIV_MUL;
          end
        end
        S_TAKE_END: begin
          if (left_q != '0) begin
            status_q <= csgc_pkg::ST_INEXACT;
          end
          acc_q   <= acc_q - TW'(paid_q);
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          // Hold the result until the output register is free.
          if (!out_valid_q || out_o.ready) begin
            out_data_q.status      <= status_q;
            out_data_q.paid_cents  <= paid_q;
            out_data_q.total_cents <= CENTS_W'(acc_q);
            out_valid_q            <= 1'b1;
            state_q                <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

@@ design/csgc_mul_unit.sv @@
// Shared registered multiplier of the coin store. It picks the constant
// operand (coin value, reciprocal or divisor) from the request.
// Depends on csgc_pkg.
module csgc_mul_unit #(
  parameter int A_W = 23
) (
  input  logic                        clk_i,
  input  csgc_pkg::mul_req_t          req_i,
  input  logic [A_W-1:0]              a_i,
  output logic [A_W+csgc_pkg::MB-1:0] prod_o
);

  localparam int MB = csgc_pkg::MB;

  logic [MB-1:0]     b_w;
  logic [A_W+MB-1:0] prod_q;

  always_comb begin
    case (req_i.op)
      csgc_pkg::MUL_VALUE:   b_w = MB'(csgc_pkg::coin_value(req_i.idx));
      csgc_pkg::MUL_RECIP:   b_w = csgc_pkg::div_recip(req_i.idx);
      csgc_pkg::MUL_DIVISOR: b_w = MB'(csgc_pkg::div_by(req_i.idx));
      default:               b_w = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {{MB{1'b0}}, a_i} * {{A_W{1'b0}}, b_w};
  end

  assign prod_o = prod_q;

endmodule

@@ bench/change_checker.sv @@
`timescale 1ns / 1ps
// Checker for the coin store: it watches the command and result channels,
// keeps its own model of the coin counts and compares every result word.
// Depends on csgc_pkg for the word types and the command and status codes.
module change_checker #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              word_valid_i,
  input  logic              word_ready_i,
  input  csgc_pkg::item_t   word_i,
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  csgc_pkg::result_t res_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  localparam int NUM_COINS = csgc_pkg::NUM_COINS;
  localparam int CENTS_W   = csgc_pkg::CENTS_W;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam longint unsigned FACE [NUM_COINS] = '{64'd50, 64'd20, 64'd10, 64'd5};

  logic [COUNT_BITS-1:0] stock [NUM_COINS];
  csgc_pkg::result_t     owed_q [$];
  csgc_pkg::result_t     want;
  int unsigned           errors;

  assign errors_o = errors;

  function automatic int coin_index(input logic [7:0] cents);
    int idx;
    idx = -1;
    for (int i = 0; i < NUM_COINS; i++) begin
      if (64'(cents) == FACE[i]) idx = i;
    end
    return idx;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] count,
                                                    input longint unsigned more);
    longint unsigned sum;
    sum = 64'(count) + more;
    return (sum > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(sum);
  endfunction

  function automatic longint unsigned stock_value();
    longint unsigned sum;
    sum = 0;
    for (int i = 0; i < NUM_COINS; i++) sum += 64'(stock[i]) * FACE[i];
    return sum;
  endfunction

  // Applies one command word to the coin counts and gives the result it earns.
  task automatic apply_command(input csgc_pkg::item_t w, output csgc_pkg::result_t r);
    logic [2:0]      st;
    longint unsigned paid;
    longint unsigned left;
    longint unsigned take;
    int              idx;
    logic [7:0]      adds [NUM_COINS];
    st   = csgc_pkg::ST_OK;
    paid = 0;
    idx  = coin_index(w.coin_cents);
    adds = '{w.add_fifty, w.add_twenty, w.add_ten, w.add_five};
    case (w.cmd)
      csgc_pkg::CMD_DEPOSIT_ONE: begin
        if (idx < 0) st = csgc_pkg::ST_UNKNOWN;
        else stock[idx] = sat_add(stock[idx], 64'd1);
      end
      csgc_pkg::CMD_DEPOSIT_CNT: begin
        for (int i = 0; i < NUM_COINS; i++) stock[i] = sat_add(stock[i], 64'(adds[i]));
      end
      csgc_pkg::CMD_TAKE_ONE: begin
        if (idx < 0) st = csgc_pkg::ST_UNKNOWN;
        else if (stock[idx] == '0) st = csgc_pkg::ST_EXHAUSTED;
        else stock[idx] = stock[idx] - COUNT_BITS'(1);
      end
      csgc_pkg::CMD_TAKE_AMOUNT: begin
        if (64'(w.amount_cents) > stock_value()) begin
          st = csgc_pkg::ST_TOO_MUCH;
        end else begin
          left = 64'(w.amount_cents);
          for (int i = 0; i < NUM_COINS; i++) begin
            take = left / FACE[i];
            if (take > 64'(stock[i])) take = 64'(stock[i]);
            stock[i] = stock[i] - COUNT_BITS'(take);
            left -= take * FACE[i];
            paid += take * FACE[i];
          end
          // Coins already taken stay taken when a remainder cannot be paid.
          if (left != 0) st = csgc_pkg::ST_INEXACT;
        end
      end
      csgc_pkg::CMD_EMPTY: begin
        paid = stock_value();
        for (int i = 0; i < NUM_COINS; i++) stock[i] = '0;
      end
      default: ;
    endcase
    r.status      = st;
    r.paid_cents  = CENTS_W'(paid);
    r.total_cents = CENTS_W'(stock_value());
  endtask

  function automatic void check_field(input string name, input longint unsigned exp_val,
                                      input longint unsigned got_val);
    if (exp_val != got_val) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, got_val);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COINS; i++) stock[i] = '0;
      owed_q.delete();
      errors    = 0;
      pending_o <= 0;
    end else begin
      // The result is taken first, so that it is never matched to a word
      // accepted on the same edge.
      if (res_valid_i && res_ready_i) begin
        if (owed_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: status %0d paid %0d total %0d",
                   $time, res_i.status, res_i.paid_cents, res_i.total_cents);
        end else begin
          want = owed_q.pop_front();
          check_field("status", 64'(want.status), 64'(res_i.status));
          check_field("paid_cents", 64'(want.paid_cents), 64'(res_i.paid_cents));
          check_field("total_cents", 64'(want.total_cents), 64'(res_i.total_cents));
        end
      end
      if (word_valid_i && word_ready_i) begin
        apply_command(word_i, want);
        owed_q.push_back(want);
      end
      pending_o <= unsigned'(owed_q.size());
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the coin store testbench: clock, reset, the command word source,
// the result sink with its stall pattern, and the verdict.
// Depends on csgc_pkg, the channel interfaces, the block and change_checker.
module tb_top;

  localparam int NUM_COINS       = csgc_pkg::NUM_COINS;
  localparam int CENTS_W         = csgc_pkg::CENTS_W;
  localparam int COUNT_BITS      = 16;
  localparam int WORD_TARGET     = 1750;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_AFTER  = 400;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SATURATE_AFTER  = 700;
  localparam int SETTLE_CYCLES   = 40;

  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  localparam logic [7:0]         FACES [NUM_COINS] = '{8'd50, 8'd20, 8'd10, 8'd5};
  localparam logic [CENTS_W-1:0] AMOUNT_MAX        = '1;
  localparam logic [CENTS_W-1:0] FULL_STORE        = CENTS_W'(((1 << COUNT_BITS) - 1) * 85);

  typedef enum {SINK_FREE, SINK_COIN_TOSS, SINK_EVERY_THIRD, SINK_SPARSE} sink_mode_e;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        held_off     = 1'b0;
  int unsigned words_taken  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned words_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned mismatches;
  int unsigned pending;

  csgc_in_if  word_ch ();
  csgc_out_if result_ch ();

  coin_store_greedy_change_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (word_ch),
    .out_o (result_ch)
  );

  change_checker #(
    .COUNT_BITS(COUNT_BITS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .word_valid_i(word_ch.valid),
    .word_ready_i(word_ch.ready),
    .word_i      (word_ch.data),
    .res_valid_i (result_ch.valid),
    .res_ready_i (result_ch.ready),
    .res_i       (result_ch.data),
    .errors_o    (mismatches),
    .pending_o   (pending)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog: any cycle without a handshake on either channel counts as quiet.
  always @(posedge clk) begin
    if (word_ch.valid && word_ch.ready) words_taken <= words_taken + 1;
    if ((word_ch.valid && word_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic csgc_pkg::item_t word_of(input logic [2:0] cmd, input logic [7:0] coin,
                                              input logic [7:0] fifty,
                                              input logic [7:0] twenty,
                                              input logic [7:0] ten, input logic [7:0] five,
                                              input logic [CENTS_W-1:0] amount);
    csgc_pkg::item_t w;
    w.cmd          = cmd;
    w.coin_cents   = coin;
    w.add_fifty    = fifty;
    w.add_twenty   = twenty;
    w.add_ten      = ten;
    w.add_five     = five;
    w.amount_cents = amount;
    return w;
  endfunction

  function automatic csgc_pkg::item_t random_word();
    csgc_pkg::item_t w;
    int unsigned     r;
    w.coin_cents   = 8'($urandom_range(0, 255));
    w.add_fifty    = 8'($urandom_range(0, 255));
    w.add_twenty   = 8'($urandom_range(0, 255));
    w.add_ten      = 8'($urandom_range(0, 255));
    w.add_five     = 8'($urandom_range(0, 255));
    w.amount_cents = CENTS_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 18) w.cmd = csgc_pkg::CMD_DEPOSIT_ONE;
    else if (r < 33) w.cmd = csgc_pkg::CMD_DEPOSIT_CNT;
    else if (r < 53) w.cmd = csgc_pkg::CMD_TAKE_ONE;
    else if (r < 83) w.cmd = csgc_pkg::CMD_TAKE_AMOUNT;
    else if (r < 88) w.cmd = csgc_pkg::CMD_EMPTY;
    else w.cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
    if ($urandom_range(0, 4) != 0) w.coin_cents = FACES[$urandom_range(0, NUM_COINS - 1)];
    if ($urandom_range(0, 9) == 0) begin
      w.add_fifty  = 8'hFF;
      w.add_twenty = 8'hFF;
      w.add_ten    = 8'hFF;
      w.add_five   = 8'hFF;
    end
    // Mostly amounts that a store of a few batches can cover.
    r = $urandom_range(0, 99);
    if (r < 35) w.amount_cents = CENTS_W'($urandom_range(0, 400));
    else if (r < 65) w.amount_cents = CENTS_W'($urandom_range(0, 40000));
    else if (r < 80) w.amount_cents = CENTS_W'(5 * $urandom_range(0, 8000));
    else if (r < 95) w.amount_cents = CENTS_W'($urandom_range(0, AMOUNT_MAX));
    else w.amount_cents = AMOUNT_MAX;
    return w;
  endfunction

  // Offers one word and returns at the edge that accepts it. Bursts of words
  // are separated by random gaps with valid low.
  task automatic send_word(input csgc_pkg::item_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        word_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    word_ch.valid <= 1'b1;
    word_ch.data  <= w;
    @(posedge clk);
    while (!word_ch.ready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  // Result sink: stall patterns that change every so often, and one long
  // hold-off so that the block fills up and refuses further words.
  initial begin
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = SINK_FREE;
    mode_left = 0;
    tick      = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (!held_off && words_taken >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 120);
        end
        mode_left--;
        case (mode)
          SINK_FREE:        result_ch.ready <= 1'b1;
          SINK_COIN_TOSS:   result_ch.ready <= 1'($urandom_range(0, 1));
          SINK_EVERY_THIRD: result_ch.ready <= (tick % 3 == 0);
          default:          result_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    csgc_pkg::item_t w;
    int unsigned     pick;
    int unsigned     n;
    logic            saturated;
    word_ch.valid = 1'b0;
    word_ch.data  = '0;
    saturated     = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Directed words on a store whose contents are known.
    send_word(word_of(csgc_pkg::CMD_TAKE_AMOUNT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, '0));
    send_word(word_of(csgc_pkg::CMD_TAKE_ONE, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0, '0));
    send_word(word_of(csgc_pkg::CMD_EMPTY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, '0));
    for (int i = 0; i < NUM_COINS; i++) begin
      send_word(word_of(csgc_pkg::CMD_DEPOSIT_ONE, FACES[i], 8'd0, 8'd0, 8'd0, 8'd0, '0));
    end
    send_word(word_of(csgc_pkg::CMD_DEPOSIT_ONE, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0, '0));
    send_word(word_of(csgc_pkg::CMD_TAKE_ONE, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0, '0));
    send_word(word_of(csgc_pkg::CMD_DEPOSIT_CNT, 8'd0, 8'hFF, 8'd0, 8'hFF, 8'd0, '0));
    send_word(word_of(csgc_pkg::CMD_DEPOSIT_CNT, 8'd0, 8'd0, 8'hFF, 8'd0, 8'hFF, '0));
    send_word(word_of(csgc_pkg::CMD_TAKE_ONE, 8'd20, 8'd0, 8'd0, 8'd0, 8'd0, '0));
    send_word(word_of(csgc_pkg::CMD_TAKE_AMOUNT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, AMOUNT_MAX));
    send_word(word_of(csgc_pkg::CMD_TAKE_AMOUNT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 23'd3));
    send_word(word_of(csgc_pkg::CMD_TAKE_AMOUNT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 23'd1235));
    send_word(word_of(CMD_SPARE_A, 8'd50, 8'hFF, 8'hFF, 8'hFF, 8'hFF, AMOUNT_MAX));
    send_word(word_of(CMD_SPARE_B, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 23'd100));
    send_word(word_of(CMD_SPARE_C, 8'd20, 8'h80, 8'h40, 8'h20, 8'h10, 23'd5));
    send_word(word_of(csgc_pkg::CMD_EMPTY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, '0));
    send_word(word_of(csgc_pkg::CMD_DEPOSIT_CNT, 8'd0, 8'd1, 8'd1, 8'd1, 8'd0, '0));
    send_word(word_of(csgc_pkg::CMD_TAKE_AMOUNT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 23'd85));
    // 75 from 50+20+10 leaves five cents that no coin can pay.
    send_word(word_of(csgc_pkg::CMD_TAKE_AMOUNT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 23'd75));
    send_word(word_of(csgc_pkg::CMD_TAKE_AMOUNT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 23'd10));
    send_word(word_of(csgc_pkg::CMD_TAKE_ONE, 8'd50, 8'd0, 8'd0, 8'd0, 8'd0, '0));

    while (words_sent < WORD_TARGET) begin
      if (!saturated && words_sent >= SATURATE_AFTER) begin
        saturated = 1'b1;
        // Full batches until every count sits at its ceiling, then coins on top.
        repeat ((1 << COUNT_BITS) / 255 + 4) begin
          send_word(word_of(csgc_pkg::CMD_DEPOSIT_CNT, 8'($urandom_range(0, 255)), 8'hFF,
                            8'hFF, 8'hFF, 8'hFF, CENTS_W'($urandom)));
        end
        for (int i = 0; i < NUM_COINS; i++) begin
          send_word(word_of(csgc_pkg::CMD_DEPOSIT_ONE, FACES[i], 8'd0, 8'd0, 8'd0, 8'd0,
                            '0));
        end
        send_word(word_of(csgc_pkg::CMD_TAKE_AMOUNT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                          AMOUNT_MAX));
        send_word(word_of(csgc_pkg::CMD_TAKE_AMOUNT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                          CENTS_W'($urandom_range(0, FULL_STORE))));
        send_word(word_of(csgc_pkg::CMD_EMPTY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, '0));
      end else if ($urandom_range(0, 9) < 7) begin
        n = $urandom_range(20, 60);
        repeat (n) send_word(random_word());
      end else begin
        // A nearly empty store, where coins run out and change is often inexact.
        send_word(word_of(csgc_pkg::CMD_EMPTY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, '0));
        n = $urandom_range(10, 25);
        repeat (n) begin
          w = random_word();
          w.coin_cents = FACES[$urandom_range(0, NUM_COINS - 1)];
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            w.cmd = csgc_pkg::CMD_DEPOSIT_ONE;
          end else if (pick < 6) begin
            w.cmd = csgc_pkg::CMD_TAKE_ONE;
          end else begin
            w.cmd          = csgc_pkg::CMD_TAKE_AMOUNT;
            w.amount_cents = CENTS_W'(5 * $urandom_range(0, 40) +
                                      ((pick == 9) ? $urandom_range(1, 4) : 0));
          end
          send_word(w);
        end
      end
    end
    word_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
